// ===== hdl/tsa_pkg.sv =====
// shared types, constants and codes for the tent spectrum accumulator
`default_nettype none
package tsa_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int IDX_W         = 17;

    // register map
    localparam logic [1:0] REG_BINS  = 2'd0;
    localparam logic [1:0] REG_START = 2'd1;
    localparam logic [1:0] REG_WIDTH = 2'd2;

    localparam logic [10:0] BINS_RESET  = 11'd1024;
    localparam logic [30:0] WIDTH_RESET = 31'd65536;

    // result status codes
    localparam logic [1:0] ST_ADD  = 2'd0;
    localparam logic [1:0] ST_DROP = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    localparam logic CMD_READ = 1'b1;

    // operand selects for the shared units
    localparam logic [1:0] MUL_SQ  = 2'd0;
    localparam logic [1:0] MUL_DEN = 2'd1;
    localparam logic [1:0] MUL_NUM = 2'd2;

    localparam logic [1:0] DIV_LO   = 2'd0;
    localparam logic [1:0] DIV_HI   = 2'd1;
    localparam logic [1:0] DIV_AREA = 2'd2;

    localparam int DIV_NW = 104;
    localparam int DIV_DW = 64;
    localparam int DIV_QW = 40;

    localparam logic signed [48:0] BIN_MAX = 49'sh0_7FFF_FFFF_FFFF;

    typedef struct packed {
        logic              command;
        logic signed [31:0] freq_a;
        logic signed [31:0] freq_b;
        logic signed [31:0] freq_c;
        logic [30:0]       amplitude;
        logic [9:0]        bin_index;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [47:0] bin_value;
    } out_t;

    typedef struct packed {
        logic [10:0]        bins_in_use;
        logic signed [31:0] start_frequency;
        logic [30:0]        bin_width;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       clr_wr;
        logic       start_mul;
        logic [1:0] mul_sel;
        logic       start_div;
        logic [1:0] div_sel;
        logic       cap_lo;
        logic       cap_hi;
        logic       check;
        logic       eval;
        logic       cap_sq;
        logic       cap_den;
        logic       cap_num;
        logic       cap_area;
        logic       rd_cap;
        logic       mem_wr;
        logic       next_bin;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic in_read;
        logic trivial;
        logic drop;
        logic last;
        logic mul_done;
        logic div_done;
        logic out_free;
        logic clr_last;
    } sts_t;

endpackage
`default_nettype wire

// ===== hdl/tsa_mul.sv =====
// 64x64 multiplier built from one 32x32 multiplier that takes the four partial products in turn
`default_nettype none
module tsa_mul (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [63:0]  a,
    input  wire logic [63:0]  b,
    output logic              done,
    output logic [127:0]      p
);
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [127:0] acc_reg;
    logic [1:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  pp;
    logic [6:0]   sh;

    assign a_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign pp     = 64'(a_half) * 64'(b_half);
    assign sh     = {cnt_reg[0] & cnt_reg[1], cnt_reg[0] ^ cnt_reg[1], 5'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 2'd3);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + (128'(pp) << sh);
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;
endmodule
`default_nettype wire

// ===== hdl/tsa_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module tsa_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [tsa_pkg::DIV_NW-1:0] num,
    input  wire logic [tsa_pkg::DIV_DW-1:0] den,
    output logic                            done,
    output logic [tsa_pkg::DIV_QW-1:0]      q,
    output logic [tsa_pkg::DIV_DW-1:0]      r
);
    import tsa_pkg::*;

    localparam int CW = $clog2(DIV_QW);

    logic [DIV_DW-1:0] r_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_QW-1:0] n_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   rs;
    logic [DIV_DW:0]   rd;
    logic              ge;

    assign rs = {r_reg, n_reg[DIV_QW-1]};
    assign ge = rs >= {1'b0, den_reg};
    assign rd = rs - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(DIV_QW - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DIV_QW - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // quotient bits shift in where numerator bits shift out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg   <= num[DIV_NW-1:DIV_QW];
            n_reg   <= num[DIV_QW-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? rd[DIV_DW-1:0] : rs[DIV_DW-1:0];
            n_reg <= {n_reg[DIV_QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign q    = n_reg;
    assign r    = r_reg;
endmodule
`default_nettype wire

// ===== hdl/tsa_ctrl.sv =====
// sequencer for read and tent add transactions
`default_nettype none
module tsa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire tsa_pkg::sts_t sts,
    output tsa_pkg::cmd_t      cmd,
    output logic               in_stall
);
    import tsa_pkg::*;

    typedef enum logic [20:0] {
        S_CLEAR     = 21'h000001,
        S_IDLE      = 21'h000002,
        S_RD        = 21'h000004,
        S_RD_DATA   = 21'h000008,
        S_DIV_LO    = 21'h000010,
        S_WAIT_LO   = 21'h000020,
        S_DIV_HI    = 21'h000040,
        S_WAIT_HI   = 21'h000080,
        S_CHECK     = 21'h000100,
        S_EVAL      = 21'h000200,
        S_MUL_SQ    = 21'h000400,
        S_WAIT_SQ   = 21'h000800,
        S_MUL_DEN   = 21'h001000,
        S_WAIT_DEN  = 21'h002000,
        S_MUL_NUM   = 21'h004000,
        S_WAIT_NUM  = 21'h008000,
        S_DIV_AREA  = 21'h010000,
        S_WAIT_AREA = 21'h020000,
        S_MEM_RD    = 21'h040000,
        S_MEM_WR    = 21'h080000,
        S_FIN       = 21'h100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_read ? S_RD : S_DIV_LO;
                end
            end
            S_RD:
                state_next = S_RD_DATA;
            S_RD_DATA:
            begin
                cmd.rd_cap = 1'b1;
                state_next = S_FIN;
            end
            S_DIV_LO:
            begin
                cmd.start_div = 1'b1;
                cmd.div_sel   = DIV_LO;
                state_next    = S_WAIT_LO;
            end
            S_WAIT_LO:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_lo = 1'b1;
                    state_next = S_DIV_HI;
                end
            end
            S_DIV_HI:
            begin
                cmd.start_div = 1'b1;
                cmd.div_sel   = DIV_HI;
                state_next    = S_WAIT_HI;
            end
            S_WAIT_HI:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_hi = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.drop ? S_FIN : S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.trivial ? S_MEM_RD : S_MUL_SQ;
            end
            S_MUL_SQ:
            begin
                cmd.start_mul = 1'b1;
                cmd.mul_sel   = MUL_SQ;
                state_next    = S_WAIT_SQ;
            end
            S_WAIT_SQ:
            begin
                if (sts.mul_done)
                begin
                    cmd.cap_sq = 1'b1;
                    state_next = S_MUL_DEN;
                end
            end
            S_MUL_DEN:
            begin
                cmd.start_mul = 1'b1;
                cmd.mul_sel   = MUL_DEN;
                state_next    = S_WAIT_DEN;
            end
            S_WAIT_DEN:
            begin
                if (sts.mul_done)
                begin
                    cmd.cap_den = 1'b1;
                    state_next  = S_MUL_NUM;
                end
            end
            S_MUL_NUM:
            begin
                cmd.start_mul = 1'b1;
                cmd.mul_sel   = MUL_NUM;
                state_next    = S_WAIT_NUM;
            end
            S_WAIT_NUM:
            begin
                if (sts.mul_done)
                begin
                    cmd.cap_num = 1'b1;
                    state_next  = S_DIV_AREA;
                end
            end
            S_DIV_AREA:
            begin
                cmd.start_div = 1'b1;
                cmd.div_sel   = DIV_AREA;
                state_next    = S_WAIT_AREA;
            end
            S_WAIT_AREA:
            begin
                cmd.div_sel = DIV_AREA;
                if (sts.div_done)
                begin
                    cmd.cap_area = 1'b1;
                    state_next   = S_MEM_RD;
                end
            end
            S_MEM_RD:
                state_next = S_MEM_WR;
            S_MEM_WR:
            begin
                cmd.mem_wr = 1'b1;
                if (sts.last)
                    state_next = S_FIN;
                else
                begin
                    cmd.next_bin = 1'b1;
                    state_next   = S_EVAL;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);
endmodule
`default_nettype wire

// ===== hdl/tsa_dp.sv =====
// datapath: operand registers, shared multiplier and divider, spectrum memory
`default_nettype none
module tsa_dp #(
    parameter int DEPTH = tsa_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tsa_pkg::cfg_t cfg,
    input  wire tsa_pkg::in_t  in_data,
    input  wire tsa_pkg::cmd_t cmd,
    output tsa_pkg::sts_t      sts,
    input  wire logic          out_stall,
    output logic               out_valid,
    output tsa_pkg::out_t      out_data
);
    import tsa_pkg::*;

    logic signed [31:0] f0_reg, f1_reg, f2_reg;
    logic [38:0]        x_reg;
    logic               is_read_reg;
    logic [9:0]         idx_reg;
    logic               neg_reg;
    logic signed [33:0] p_reg, pmax_reg;
    logic [AW-1:0]      k_reg;
    logic signed [34:0] edge_reg;
    logic               rising_reg;
    logic [31:0]        u_reg;
    logic [63:0]        sq_reg, den_reg;
    logic [103:0]       num_reg;
    logic [38:0]        cur_reg, prev_reg;
    logic [1:0]         status_reg;
    logic [47:0]        value_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [47:0]        rd_data_reg;
    logic               out_valid_reg;
    out_t               out_data_reg;
    logic [47:0]        mem [DEPTH];

    // three-corner sort
    logic signed [31:0] lo1, hi1, lo2, s_lo, s_mid, s_hi;
    always_comb
    begin
        lo1   = (in_data.freq_a <= in_data.freq_b) ? in_data.freq_a : in_data.freq_b;
        hi1   = (in_data.freq_a <= in_data.freq_b) ? in_data.freq_b : in_data.freq_a;
        lo2   = (hi1 <= in_data.freq_c) ? hi1 : in_data.freq_c;
        s_hi  = (hi1 <= in_data.freq_c) ? in_data.freq_c : hi1;
        s_lo  = (lo1 <= lo2) ? lo1 : lo2;
        s_mid = (lo1 <= lo2) ? lo2 : lo1;
    end

    // bin index division operands
    logic signed [31:0] bin_f;
    logic signed [32:0] diff;
    logic [32:0]        mag;
    assign bin_f = (cmd.div_sel == DIV_HI) ? f2_reg : f0_reg;
    assign diff  = 33'(bin_f) - 33'(cfg.start_frequency);
    assign mag   = diff[32] ? 33'(-diff) : 33'(diff);

    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic              div_done;
    logic [DIV_QW-1:0] div_q;
    logic [DIV_DW-1:0] div_r;
    logic              remnz;

    assign div_num = (cmd.div_sel == DIV_AREA) ? num_reg : DIV_NW'(mag);
    assign div_den = (cmd.div_sel == DIV_AREA) ? den_reg : DIV_DW'(cfg.bin_width);
    assign remnz   = (div_r != '0);

    tsa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_div),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .q     (div_q),
        .r     (div_r)
    );

    // floor division result and the upper edge of the lowest bin
    logic [33:0]        q34;
    logic signed [33:0] floor_q;
    logic [30:0]        rf;
    logic signed [34:0] edge1;
    assign q34     = 34'(div_q[32:0]) + 34'(neg_reg & remnz);
    assign floor_q = neg_reg ? -signed'(q34) : signed'(q34);
    assign rf      = (neg_reg && remnz) ? (cfg.bin_width - div_r[30:0]) : div_r[30:0];
    assign edge1   = 35'(f0_reg) - 35'(rf) + 35'(cfg.bin_width);

    // range check
    logic [IDX_W-1:0]   eff;
    logic signed [33:0] eff_s;
    logic               drop;
    assign eff   = (IDX_W'(cfg.bins_in_use) > IDX_W'(DEPTH)) ? IDX_W'(DEPTH)
                                                              : IDX_W'(cfg.bins_in_use);
    assign eff_s = 34'(eff);
    assign drop  = (p_reg < 0) || (pmax_reg >= eff_s);

    // edge classification
    logic signed [34:0] e0, e1, e2, u_up, u_dn;
    logic               le0, ge2, rising;
    assign e0     = 35'(f0_reg);
    assign e1     = 35'(f1_reg);
    assign e2     = 35'(f2_reg);
    assign le0    = edge_reg <= e0;
    assign ge2    = edge_reg >= e2;
    assign rising = edge_reg < e1;
    assign u_up   = edge_reg - e0;
    assign u_dn   = e2 - edge_reg;

    logic [32:0] d33, side33;
    assign d33    = 33'(f2_reg) - 33'(f0_reg);
    assign side33 = rising_reg ? (33'(f1_reg) - 33'(f0_reg)) : (33'(f2_reg) - 33'(f1_reg));

    logic [63:0]  mul_a, mul_b;
    logic         mul_done;
    logic [127:0] mul_p;
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SQ:
            begin
                mul_a = 64'(u_reg);
                mul_b = 64'(u_reg);
            end
            MUL_DEN:
            begin
                mul_a = 64'(d33[31:0]);
                mul_b = 64'(side33[31:0]);
            end
            MUL_NUM:
            begin
                mul_a = 64'(x_reg);
                mul_b = sq_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    tsa_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_mul),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    // saturating accumulate
    logic [38:0]        amount;
    logic signed [48:0] sum;
    logic [47:0]        sum_sat;
    assign amount  = cur_reg - prev_reg;
    assign sum     = 49'(signed'(rd_data_reg)) + signed'(49'(amount));
    assign sum_sat = (sum > BIN_MAX) ? BIN_MAX[47:0] : sum[47:0];

    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [47:0]   wdata;
    logic          we;
    logic          in_range;
    assign raddr    = is_read_reg ? AW'(idx_reg) : k_reg;
    assign waddr    = cmd.clr_wr ? clr_addr_reg : k_reg;
    assign wdata    = cmd.clr_wr ? 48'd0 : sum_sat;
    assign we       = cmd.clr_wr | cmd.mem_wr;
    assign in_range = IDX_W'(idx_reg) < IDX_W'(DEPTH);

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            f0_reg      <= s_lo;
            f1_reg      <= s_mid;
            f2_reg      <= s_hi;
            x_reg       <= {in_data.amplitude, 8'd0};
            is_read_reg <= in_data.command == CMD_READ;
            idx_reg     <= in_data.bin_index;
            prev_reg    <= '0;
            value_reg   <= '0;
        end
        if (cmd.start_div && cmd.div_sel != DIV_AREA)
            neg_reg <= diff[32];
        if (cmd.cap_lo)
        begin
            p_reg    <= floor_q;
            edge_reg <= edge1;
        end
        if (cmd.cap_hi)
            pmax_reg <= floor_q;
        if (cmd.check)
        begin
            status_reg <= drop ? ST_DROP : ST_ADD;
            k_reg      <= p_reg[AW-1:0];
        end
        if (cmd.eval)
        begin
            rising_reg <= rising;
            u_reg      <= rising ? u_up[31:0] : u_dn[31:0];
            if (le0)
                cur_reg <= '0;
            else if (ge2)
                cur_reg <= x_reg;
        end
        if (cmd.cap_sq)
            sq_reg <= mul_p[63:0];
        if (cmd.cap_den)
            den_reg <= mul_p[63:0];
        if (cmd.cap_num)
            num_reg <= mul_p[103:0];
        if (cmd.cap_area)
            cur_reg <= rising_reg ? div_q[38:0] : (x_reg - div_q[38:0] - 39'(remnz));
        if (cmd.rd_cap)
        begin
            status_reg <= ST_READ;
            value_reg  <= in_range ? rd_data_reg : 48'd0;
        end
        if (cmd.next_bin)
        begin
            prev_reg <= cur_reg;
            k_reg    <= k_reg + AW'(1);
            edge_reg <= edge_reg + 35'(cfg.bin_width);
        end
        if (cmd.out_load)
            out_data_reg <= '{status: status_reg, bin_value: signed'(value_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            clr_addr_reg  <= '0;
        end
        else
        begin
            if (cmd.clr_wr)
                clr_addr_reg <= clr_addr_reg + AW'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign sts.in_read  = in_data.command == CMD_READ;
    assign sts.trivial  = le0 | ge2;
    assign sts.drop     = drop;
    assign sts.last     = k_reg == pmax_reg[AW-1:0];
    assign sts.mul_done = mul_done;
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || !out_stall;
    assign sts.clr_last = clr_addr_reg == AW'(DEPTH - 1);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
endmodule
`default_nettype wire

// ===== hdl/tent_spectrum_accumulator_top.sv =====
// tent spectrum accumulator: one result per transaction, iterative per-bin area
// read: the addressed word is read, captured and loaded into the output register;
// add: two divides find the bin range, then each bin wholly below or above the tent
// only updates memory, while each bin it crosses first runs three multiplies and an
// area divide; reset initialises the control and config registers at once, and a
// clearing pass then zeroes the spectrum memory before the first transaction is taken
`default_nettype none
module tent_spectrum_accumulator_top #(
    parameter int SPECTRUM_DEPTH = tsa_pkg::DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire tsa_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output tsa_pkg::out_t      out_data,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tsa_pkg::*;

    localparam int AW = $clog2(SPECTRUM_DEPTH);

    logic [10:0]        bins_reg;
    logic signed [31:0] start_reg;
    logic [30:0]        width_reg;
    logic [1:0]         reg_idx;
    logic               wr_en;
    cfg_t               cfg;
    cmd_t               cmd;
    sts_t               sts;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_reg  <= BINS_RESET;
            start_reg <= '0;
            width_reg <= WIDTH_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_BINS:  bins_reg  <= pwdata[10:0];
                REG_START: start_reg <= signed'(pwdata);
                REG_WIDTH: width_reg <= (pwdata[30:0] == '0) ? 31'd1 : pwdata[30:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_BINS:  prdata = 32'(bins_reg);
            REG_START: prdata = start_reg;
            REG_WIDTH: prdata = 32'(width_reg);
            default:   prdata = '0;
        endcase
    end

    assign cfg = '{bins_in_use: bins_reg, start_frequency: start_reg, bin_width: width_reg};

    tsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    tsa_dp #(
        .DEPTH (SPECTRUM_DEPTH),
        .AW    (AW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );
endmodule
`default_nettype wire
